// ===== hdl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared widths, operation codes and sequencer states of the indexed
// max-heap priority queue.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int ID_W      = 6;
  localparam int ID_N      = 1 << ID_W;
  localparam int PRIO_W    = 32;
  localparam int OP_W      = 3;
  localparam int FILL_W    = 7;
  localparam int DEF_MAX   = 64;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_RAISE   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOWER   = 3'd2;
  localparam logic [OP_W-1:0] OP_EXTRACT = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_XTOP,
    S_XLAST,
    S_XLPRIO,
    S_UP,
    S_UP1,
    S_UP2,
    S_DN,
    S_DN1,
    S_DN2,
    S_DN3,
    S_DONE
  } imh_state_t;

endpackage

// ===== hdl/indexed_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Each heap level of a sift costs dependent memory reads: a sift up reads the
// parent's id and then its priority, a sift down reads the children's ids and
// priorities. One word at a time: in_tready returns with the result, so no new
// word is taken while an operation is in flight or waits for the output register.
// Reset: synchronous, active low; clears count, presence bits and handshakes.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue
  import imh_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // op[2:0], elem_id[8:3], prio_in[40:9], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // ok[0], id_out[6:1], prio_out[38:7], fill_count[45:39], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int POS_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CH_W  = POS_W + 2;

  logic [ID_W-1:0]   heap_mem [MAX_ELEMENTS];
  logic [POS_W-1:0]  slot_mem [ID_N];
  logic [PRIO_W-1:0] prio_mem [ID_N];

  logic              heap_we, slot_we, prio_we;
  logic [POS_W-1:0]  heap_wa, heap_ra, slot_wd;
  logic [ID_W-1:0]   heap_wd, slot_wa, slot_ra, prio_wa, prio_ra;
  logic [PRIO_W-1:0] prio_wd;
  logic              heap_re, slot_re, prio_re;
  logic [ID_W-1:0]   heap_q;
  logic [POS_W-1:0]  slot_q;
  logic [PRIO_W-1:0] prio_q;

  imh_state_t state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt, me_r, me_nxt, lid_r, lid_nxt, rid_r, rid_nxt;
  logic [PRIO_W-1:0] pin_r, pin_nxt, mp_r, mp_nxt, lp_r, lp_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ID_N-1:0]   present_r, present_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [PRIO_W-1:0] res_prio_r, res_prio_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [CH_W-1:0]  lpos, rpos, cnt_ext;
  logic             l_in, r_in, valid_id, l_win, r_win;
  logic [POS_W-1:0] parent;

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_q <= heap_mem[heap_ra];
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_q <= slot_mem[slot_ra];
    if (prio_we) prio_mem[prio_wa] <= prio_wd;
    if (prio_re) prio_q <= prio_mem[prio_ra];
  end

  assign lpos     = {1'b0, pos_r, 1'b1};
  assign rpos     = lpos + CH_W'(1);
  assign cnt_ext  = CH_W'(count_r);
  assign l_in     = lpos < cnt_ext;
  assign r_in     = rpos < cnt_ext;
  assign parent   = (pos_r - POS_W'(1)) >> 1;
  assign valid_id = 32'(id_r) < 32'(MAX_ELEMENTS);
  assign l_win    = $signed(lp_r) > $signed(mp_r);
  assign r_win    = r_in && (l_win ? ($signed(prio_q) > $signed(lp_r))
                                   : ($signed(prio_q) > $signed(mp_r)));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    pin_r      <= pin_nxt;
    me_r       <= me_nxt;
    mp_r       <= mp_nxt;
    lid_r      <= lid_nxt;
    rid_r      <= rid_nxt;
    lp_r       <= lp_nxt;
    pos_r      <= pos_nxt;
    res_ok_r   <= res_ok_nxt;
    res_id_r   <= res_id_nxt;
    res_prio_r <= res_prio_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    pin_nxt       = pin_r;
    me_nxt        = me_r;
    mp_nxt        = mp_r;
    lid_nxt       = lid_r;
    rid_nxt       = rid_r;
    lp_nxt        = lp_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    present_nxt   = present_r;
    res_ok_nxt    = res_ok_r;
    res_id_nxt    = res_id_r;
    res_prio_nxt  = res_prio_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    heap_we = 1'b0; heap_wa = pos_r; heap_wd = me_r;
    slot_we = 1'b0; slot_wa = me_r;  slot_wd = pos_r;
    prio_we = 1'b0; prio_wa = id_r;  prio_wd = pin_r;
    heap_re = 1'b0; heap_ra = '0;
    slot_re = 1'b0; slot_ra = id_r;
    prio_re = 1'b0; prio_ra = id_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tdata[2:0];
          id_nxt  = in_tdata[8:3];
          pin_nxt = in_tdata[40:9];
          heap_re = 1'b1;
          slot_re = 1'b1;
          slot_ra = in_tdata[8:3];
          prio_re = 1'b1;
          prio_ra = in_tdata[8:3];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_ok_nxt   = 1'b0;
        res_id_nxt   = id_r;
        res_prio_nxt = '0;
        me_nxt       = id_r;
        mp_nxt       = pin_r;
        state_nxt    = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (valid_id && !present_r[id_r] && (32'(count_r) < 32'(MAX_ELEMENTS))) begin
              prio_we      = 1'b1;
              present_nxt[id_r] = 1'b1;
              pos_nxt      = POS_W'(count_r);
              count_nxt    = count_r + CNT_W'(1);
              res_ok_nxt   = 1'b1;
              res_prio_nxt = pin_r;
              state_nxt    = S_UP;
            end
          end
          OP_RAISE, OP_LOWER: begin
            if (valid_id && present_r[id_r] &&
                ((op_r == OP_RAISE) ? ($signed(pin_r) > $signed(prio_q))
                                    : ($signed(pin_r) < $signed(prio_q)))) begin
              prio_we      = 1'b1;
              pos_nxt      = slot_q;
              res_ok_nxt   = 1'b1;
              res_prio_nxt = pin_r;
              state_nxt    = (op_r == OP_RAISE) ? S_UP : S_DN;
            end
          end
          OP_QUERY: begin
            if (valid_id && present_r[id_r]) begin
              res_ok_nxt   = 1'b1;
              res_prio_nxt = prio_q;
            end
          end
          OP_EXTRACT: begin
            res_id_nxt = '0;
            if (count_r != '0) begin
              res_id_nxt = heap_q;
              prio_re    = 1'b1;
              prio_ra    = heap_q;
              state_nxt  = S_XTOP;
            end
          end
          default: ;
        endcase
      end
      S_XTOP: begin
        res_ok_nxt   = 1'b1;
        res_prio_nxt = prio_q;
        present_nxt[res_id_r] = 1'b0;
        count_nxt    = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = POS_W'(count_r - CNT_W'(1));
          state_nxt = S_XLAST;
        end
      end
      S_XLAST: begin
        me_nxt    = heap_q;
        prio_re   = 1'b1;
        prio_ra   = heap_q;
        state_nxt = S_XLPRIO;
      end
      S_XLPRIO: begin
        mp_nxt    = prio_q;
        pos_nxt   = '0;
        state_nxt = S_DN;
      end
      S_UP: begin
        if (pos_r == '0) begin
          heap_we   = 1'b1;
          slot_we   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = parent;
          state_nxt = S_UP1;
        end
      end
      S_UP1: begin
        lid_nxt   = heap_q;
        prio_re   = 1'b1;
        prio_ra   = heap_q;
        state_nxt = S_UP2;
      end
      S_UP2: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if ($signed(mp_r) > $signed(prio_q)) begin
          heap_wd   = lid_r;
          slot_wa   = lid_r;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN: begin
        if (!l_in) begin
          heap_we   = 1'b1;
          slot_we   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          heap_re   = 1'b1;
          heap_ra   = POS_W'(lpos);
          state_nxt = S_DN1;
        end
      end
      S_DN1: begin
        lid_nxt   = heap_q;
        prio_re   = 1'b1;
        prio_ra   = heap_q;
        heap_re   = r_in;
        heap_ra   = POS_W'(rpos);
        state_nxt = S_DN2;
      end
      S_DN2: begin
        lp_nxt    = prio_q;
        rid_nxt   = heap_q;
        prio_re   = r_in;
        prio_ra   = heap_q;
        state_nxt = S_DN3;
      end
      S_DN3: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        if (r_win) begin
          heap_wd   = rid_r;
          slot_wa   = rid_r;
          pos_nxt   = POS_W'(rpos);
          state_nxt = S_DN;
        end else if (l_win) begin
          heap_wd   = lid_r;
          slot_wa   = lid_r;
          pos_nxt   = POS_W'(lpos);
          state_nxt = S_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, FILL_W'(count_r), res_prio_r, res_id_r, res_ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/imh_checker.sv =====
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks on the result stream of the heap queue.
// ----------------------------------------------------------------------------
module imh_checker
  import imh_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[45:39] <= 7'd64)
    else $error("fill count above capacity");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[38:7] == 32'd0)
    else $error("rejected word carries a priority");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken before the first finished");

endmodule

bind indexed_max_heap_queue imh_checker u_imh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
